### hdl/ptbg_pkg.sv
`default_nettype none
package ptbg_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned TINT_W  = 32;
    localparam int unsigned GAMMA_N = 256;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_BLEND = 1'b1
    } opcode_t;

    // one item as it moves down the tint stages
    typedef struct packed {
        opcode_t             opcode;
        logic [CHAN_W-1:0]   entry_index;
        logic [CHAN_W-1:0]   entry_value;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
    } item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] percent;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } tint_t;

    // c + floor(pct * (dst - c) / 256); stays within 0..255 for pct <= 255
    function automatic logic [CHAN_W-1:0] tint_step(
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] dst,
        input logic [CHAN_W-1:0] pct
    );
        logic signed [CHAN_W:0]       diff;
        logic signed [2*CHAN_W+1:0]   prod;
        logic        [CHAN_W+1:0]     sum;
        diff = $signed({1'b0, dst}) - $signed({1'b0, c});
        prod = $signed({1'b0, pct}) * diff;
        sum  = {2'b00, c} + prod[2*CHAN_W+1:CHAN_W];
        return sum[CHAN_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hdl/ptbg_tint_stage.sv
`default_nettype none
module ptbg_tint_stage
    import ptbg_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [TINT_W-1:0]   tint,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire item_t               in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output item_t                    out_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    tint_t t;

    assign t        = tint_t'(tint);
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        item_next       = in_item;
        item_next.red   = tint_step(in_item.red,   t.red,   t.percent);
        item_next.green = tint_step(in_item.green, t.green, t.percent);
        item_next.blue  = tint_step(in_item.blue,  t.blue,  t.percent);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

### hdl/ptbg_gamma_lut.sv
`default_nettype none
module ptbg_gamma_lut
    import ptbg_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire item_t                 in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [CHAN_W-1:0]          red_out,
    output logic [CHAN_W-1:0]          green_out,
    output logic [CHAN_W-1:0]          blue_out
);

    // one copy per channel so each has a single read port
    logic [CHAN_W-1:0] mem_r [GAMMA_N];
    logic [CHAN_W-1:0] mem_g [GAMMA_N];
    logic [CHAN_W-1:0] mem_b [GAMMA_N];

    logic [GAMMA_N-1:0] ent_valid_reg;
    logic               valid_reg;
    logic [CHAN_W-1:0]  rd_r_reg, rd_g_reg, rd_b_reg;
    logic [CHAN_W-1:0]  addr_r_reg, addr_g_reg, addr_b_reg;
    logic [2:0]         hit_reg;
    logic               take;
    logic               do_load;
    logic               do_blend;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_ready && in_valid;
    assign do_load  = take && (in_item.opcode == OP_LOAD);
    assign do_blend = take && (in_item.opcode == OP_BLEND);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            ent_valid_reg <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= do_blend;
            end
            if (do_load) begin
                ent_valid_reg[in_item.entry_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            mem_r[in_item.entry_index] <= in_item.entry_value;
            mem_g[in_item.entry_index] <= in_item.entry_value;
            mem_b[in_item.entry_index] <= in_item.entry_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_blend) begin
            rd_r_reg   <= mem_r[in_item.red];
            rd_g_reg   <= mem_g[in_item.green];
            rd_b_reg   <= mem_b[in_item.blue];
            addr_r_reg <= in_item.red;
            addr_g_reg <= in_item.green;
            addr_b_reg <= in_item.blue;
            hit_reg    <= {ent_valid_reg[in_item.blue],
                           ent_valid_reg[in_item.green],
                           ent_valid_reg[in_item.red]};
        end
    end

    // an entry never loaded reads as identity
    assign red_out   = hit_reg[0] ? rd_r_reg : addr_r_reg;
    assign green_out = hit_reg[1] ? rd_g_reg : addr_g_reg;
    assign blue_out  = hit_reg[2] ? rd_b_reg : addr_b_reg;
    assign out_valid = valid_reg;

endmodule
`default_nettype wire

### hdl/palette_tint_blend_gamma.sv
`default_nettype none
// Pipeline: a register in each tint stage, then one for the gamma table read, between input
//   transaction and result.
// Throughput: one item per cycle unless the result stream stalls; every stage holds its own
//   valid bit, so bubbles close up under output back-pressure. Loads produce no result.
// Reset: synchronous, active low; tints clear to zero and the gamma table reads identity.
module palette_tint_blend_gamma
    import ptbg_pkg::*;
#(
    parameter int unsigned NUM_TINTS = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // config write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // entry_index, entry_value, red_in, green_in, blue_in
    input  wire logic [0:0]   s_tuser,   // opcode
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata    // red_out, green_out, blue_out
);

    logic [TINT_W-1:0] tint_reg [NUM_TINTS];

    item_t stg_item  [NUM_TINTS+1];
    logic  stg_valid [NUM_TINTS+1];
    logic  stg_ready [NUM_TINTS+1];

    assign cfg_ready = 1'b1;

    for (genvar k = 0; k < NUM_TINTS; k++) begin : g_tint_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tint_reg[k] <= '0;
            end else if (cfg_valid && (cfg_index == 8'(k))) begin
                tint_reg[k] <= cfg_data;
            end
        end
    end

    assign stg_item[0].opcode      = opcode_t'(s_tuser[0]);
    assign stg_item[0].entry_index = s_tdata[7:0];
    assign stg_item[0].entry_value = s_tdata[15:8];
    assign stg_item[0].red         = s_tdata[23:16];
    assign stg_item[0].green       = s_tdata[31:24];
    assign stg_item[0].blue        = s_tdata[39:32];
    assign stg_valid[0]            = s_tvalid;
    assign s_tready                = stg_ready[0];

    for (genvar k = 0; k < NUM_TINTS; k++) begin : g_stage
        ptbg_tint_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .tint      (tint_reg[k]),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_item   (stg_item[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_item  (stg_item[k+1])
        );
    end

    ptbg_gamma_lut u_gamma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stg_valid[NUM_TINTS]),
        .in_ready  (stg_ready[NUM_TINTS]),
        .in_item   (stg_item[NUM_TINTS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red_out   (m_tdata[7:0]),
        .green_out (m_tdata[15:8]),
        .blue_out  (m_tdata[23:16])
    );

endmodule
`default_nettype wire

### test/tb_palette_tint_blend_gamma.sv
`default_nettype none
module tb_palette_tint_blend_gamma;
    import ptbg_pkg::*;

    localparam int NUM_TINTS    = 4;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 12;    // pipeline depth plus margin
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int RAND_ITEMS   = 245;   // per idling phase
    localparam int NUM_DIRECTED = 20;
    localparam int TINTED_FROM  = 9;     // directed rows from here run with tints set

    localparam logic [7:0] REG_TINT0 = 8'd0;
    localparam logic [7:0] REG_TINT1 = 8'd1;
    localparam logic [7:0] REG_TINT2 = 8'd2;
    localparam logic [7:0] REG_TINT3 = 8'd3;
    localparam logic [7:0] NUM_REGS  = 8'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct {
        opcode_t    op;
        logic [7:0] idx;
        logic [7:0] val;
        rgb_t       color;
        bit         typed;
        rgb_t       want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // entry_index, entry_value, red_in, green_in, blue_in
    logic [0:0]  s_tuser;    // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // red_out, green_out, blue_out

    tint_t       tint_shadow [NUM_TINTS];
    logic [7:0]  gamma_shadow [256];
    rgb_t        pending_colors [$];
    int          mismatches;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int          stall_cycles;

    palette_tint_blend_gamma #(
        .NUM_TINTS(NUM_TINTS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // c + floor(pct * (dst - c) / 256), floor taken by the arithmetic shift
    function automatic logic [7:0] mix_channel(logic [7:0] c, logic [7:0] dst,
                                               logic [7:0] pct);
        int delta;
        int scaled;
        delta  = int'(dst) - int'(c);
        scaled = int'(pct) * delta;
        return 8'(int'(c) + (scaled >>> 8));
    endfunction

    function automatic rgb_t tinted_gamma_color(rgb_t base);
        rgb_t c;
        c = base;
        for (int k = 0; k < NUM_TINTS; k++) begin
            c.red   = mix_channel(c.red,   tint_shadow[k].red,   tint_shadow[k].percent);
            c.green = mix_channel(c.green, tint_shadow[k].green, tint_shadow[k].percent);
            c.blue  = mix_channel(c.blue,  tint_shadow[k].blue,  tint_shadow[k].percent);
        end
        c.red   = gamma_shadow[c.red];
        c.green = gamma_shadow[c.green];
        c.blue  = gamma_shadow[c.blue];
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %02h, expected %02h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [31:0] data, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < NUM_REGS)
            tint_shadow[idx] = tint_t'(data);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic write_tint_set(logic [31:0] t0, logic [31:0] t1, logic [31:0] t2,
                                  logic [31:0] t3);
        cfg_write(REG_TINT0, t0, 1'b0);
        cfg_write(REG_TINT1, t1, 1'b0);
        cfg_write(REG_TINT2, t2, 1'b0);
        cfg_write(REG_TINT3, t3, 1'b0);
        // an index past the last tint must leave every register alone
        cfg_write(8'($urandom_range(NUM_REGS, 255)), $urandom(), 1'b1);
    endtask

    // loads still in flight give no result, so let the pipeline empty as well
    task automatic wait_drained();
        while (pending_colors.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_item(opcode_t op, logic [7:0] idx, logic [7:0] val, rgb_t color,
                             bit typed, rgb_t want);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {color.blue, color.green, color.red, val, idx};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        if (op == OP_LOAD)
            gamma_shadow[idx] = val;
        else if (typed)
            pending_colors.push_back(want);
        else
            pending_colors.push_back(tinted_gamma_color(color));
    endtask

    // result side: check each transaction, then pick the next ready
    initial begin
        rgb_t got;
        rgb_t want;
        int   hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = rgb_t'({m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]});
                if (pending_colors.size() == 0) begin
                    report_mismatch("unexpected result, red_out", got.red, 'x);
                end else begin
                    want = pending_colors.pop_front();
                    if (got.red !== want.red)
                        report_mismatch("red_out", got.red, want.red);
                    if (got.green !== want.green)
                        report_mismatch("green_out", got.green, want.green);
                    if (got.blue !== want.blue)
                        report_mismatch("blue_out", got.blue, want.blue);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        stall_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t  directed_rows [NUM_DIRECTED];
        opcode_t    op;
        rgb_t       color;
        logic [31:0] t [NUM_TINTS];

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        mismatches  = 0;
        hold_req    = 1'b0;
        tx_idle_pct = 16;
        rx_idle_pct = 87;
        for (int k = 0; k < NUM_TINTS; k++)
            tint_shadow[k] = '0;
        for (int i = 0; i < 256; i++)
            gamma_shadow[i] = 8'(i);

        // with zero tints and an identity table a blend returns its input
        directed_rows = '{
            '{OP_BLEND, 8'h00, 8'h00, 24'h000000, 1'b1, 24'h000000},
            '{OP_BLEND, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
            '{OP_BLEND, 8'h5A, 8'hA5, 24'h01807F, 1'b1, 24'h01807F},
            '{OP_LOAD,  8'hFF, 8'h00, 24'hFFFFFF, 1'b0, 24'h000000},
            '{OP_LOAD,  8'h00, 8'hFF, 24'h000000, 1'b0, 24'h000000},
            '{OP_BLEND, 8'h00, 8'h00, 24'hFF00FF, 1'b1, 24'h00FF00},
            '{OP_LOAD,  8'hFF, 8'hFF, 24'h123456, 1'b0, 24'h000000},
            '{OP_LOAD,  8'h00, 8'h00, 24'hABCDEF, 1'b0, 24'h000000},
            '{OP_BLEND, 8'h33, 8'hCC, 24'h00FF00, 1'b1, 24'h00FF00},
            '{OP_BLEND, 8'h00, 8'h00, 24'h000000, 1'b0, 24'h000000},
            '{OP_BLEND, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b0, 24'h000000},
            '{OP_BLEND, 8'h01, 8'h02, 24'h807F01, 1'b0, 24'h000000},
            '{OP_LOAD,  8'h80, 8'h3C, 24'hFFFFFF, 1'b0, 24'h000000},
            '{OP_BLEND, 8'h00, 8'h00, 24'h808080, 1'b0, 24'h000000},
            '{OP_BLEND, 8'hC3, 8'h3C, 24'hFE0155, 1'b0, 24'h000000},
            '{OP_LOAD,  8'h01, 8'hFE, 24'h000000, 1'b0, 24'h000000},
            '{OP_BLEND, 8'h00, 8'h00, 24'h010101, 1'b0, 24'h000000},
            '{OP_BLEND, 8'hFF, 8'h00, 24'hAA5533, 1'b0, 24'h000000},
            '{OP_LOAD,  8'h12, 8'h00, 24'h5A5A5A, 1'b0, 24'h000000},
            '{OP_BLEND, 8'h00, 8'hFF, 24'h123456, 1'b0, 24'h000000}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (i == TINTED_FROM) begin
                s_tvalid <= 1'b0;
                wait_drained();
                // strong pull of red to black and green to white, a half pull back,
                // a nudge, then a no-op tint
                write_tint_set(32'hFF00FF80, 32'h80FF0040, 32'h01123456, 32'h00FFFFFF);
            end
            send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                      directed_rows[i].color, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        for (int phase = 0; phase < 3; phase++) begin
            s_tvalid <= 1'b0;
            wait_drained();
            case (phase)
                0: begin
                    tx_idle_pct = 16;
                    rx_idle_pct = 87;
                    for (int k = 0; k < NUM_TINTS; k++)
                        t[k] = $urandom();
                end
                1: begin
                    tx_idle_pct = 87;
                    rx_idle_pct = 16;
                    for (int k = 0; k < NUM_TINTS; k++)
                        t[k] = {8'hFF, 24'($urandom())};
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    t[0] = 32'hFFFFFFFF;
                    t[1] = 32'h00000000;
                    t[2] = $urandom();
                    t[3] = {8'($urandom_range(0, 255)), 24'h000000};
                end
            endcase
            write_tint_set(t[0], t[1], t[2], t[3]);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                // stall the result side while inputs keep coming
                if (phase == 2 && n == 60)
                    hold_req = 1'b1;
                op    = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_BLEND;
                color = rgb_t'(24'($urandom()));
                send_item(op, 8'($urandom()), 8'($urandom()), color, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        wait_drained();

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
